@@ hdl/madl_pkg.sv @@
`default_nettype none

package madl_pkg;

    localparam int AUDIO_W = 12;
    localparam int KNOB_W  = 12;
    localparam int MODE_W  = 3;
    localparam int SEL_W   = 2;
    localparam int TIDX_W  = 10;
    localparam int TVAL_W  = 14;
    localparam int OFS_W   = 10;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [AUDIO_W-1:0]   audio_t;
    typedef logic [KNOB_W-1:0]    knob_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [SEL_W-1:0]     sel_t;
    typedef logic [TIDX_W-1:0]    tidx_t;
    typedef logic [TVAL_W-1:0]    tval_t;
    typedef logic [OFS_W-1:0]     ofs_t;
    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_TABLE = 1'b1;

    localparam mode_t MODE_A      = 3'd0;
    localparam mode_t MODE_B      = 3'd1;
    localparam mode_t MODE_DIRECT = 3'd2;
    localparam mode_t MODE_MULTI  = 3'd3;

    localparam sel_t SEL_A = 2'd0;
    localparam sel_t SEL_B = 2'd1;
    localparam sel_t SEL_C = 2'd2;

    // where a tick takes its delay from
    typedef enum logic [1:0] {
        KIND_A,
        KIND_B,
        KIND_DIRECT,
        KIND_C
    } tap_kind_t;

endpackage

`default_nettype wire

@@ hdl/multimode_audio_delay_line_unit.sv @@
// Multimode audio delay line.
// Input channel (in_valid / in_stall) carries one item per transfer: either a
// sample tick (action 0) or a delay table entry write (action 1). Output
// channel (out_valid / out_stall) carries delayed_sample items; only ticks
// that read the sample store produce one (modes 0..3 on their work phase).
// Phase offsets for mode 3 are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce this. Throughput: one item per cycle while the output is not
// stalled. A result passes table read, delay reduction and store access with
// registered read data, then is held until taken.
// The sample store is one memory with one write and one read port, accessed
// in a single pipeline stage in item order; a read of the entry that the same
// tick writes is forwarded. Entries never written since reset read as zero
// through a fill position and wrap flag, so no clearing pass is needed.
// Reset clears position, latched knob, phase, offsets and pipeline valids.
// A stalled output holds its item; the pipeline keeps filling behind it and
// in_stall rises only once all three stages hold items.
`default_nettype none

module multimode_audio_delay_line_unit #(
    parameter int STORE_DEPTH = 16384,
    parameter int KNOB_STEPS  = 1024
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire                  action,
    input  madl_pkg::mode_t      mode,
    input  madl_pkg::audio_t     audio_in,
    input  madl_pkg::knob_t      delay_knob,
    input  madl_pkg::sel_t       table_select,
    input  madl_pkg::tidx_t      table_index,
    input  madl_pkg::tval_t      table_value,
    output logic                 out_valid,
    input  wire                  out_stall,
    output madl_pkg::audio_t     delayed_sample,
    input  wire                  cfg_we,
    input  madl_pkg::cfg_idx_t   cfg_index,
    input  madl_pkg::ofs_t       cfg_data
);
    import madl_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int KW = $clog2(KNOB_STEPS);
    // three delay tables share one memory, addressed by {select, entry}
    localparam int TBL_DEPTH = 3 << KW;
    // quotient bits of the reductions: up to 16383 / STORE_DEPTH and 1023 / KNOB_STEPS
    localparam int DSTEPS = 4;
    localparam int KSTEPS = 6;

    function automatic logic [KW-1:0] knob_mod(input ofs_t v);
        ofs_t r;
        r = v;
        for (int k = KSTEPS - 1; k >= 0; k--) begin
            if (32'(r) >= (KNOB_STEPS << k))
                r = r - OFS_W'(KNOB_STEPS << k);
        end
        return KW'(r);
    endfunction

    function automatic logic [AW-1:0] depth_mod(input tval_t v);
        tval_t r;
        r = v;
        for (int k = DSTEPS - 1; k >= 0; k--) begin
            if (32'(r) >= (STORE_DEPTH << k))
                r = r - TVAL_W'(STORE_DEPTH << k);
        end
        return AW'(r);
    endfunction

    // architectural state
    logic [AW-1:0] wp_reg, wp_next;
    logic          full_reg, full_next;
    ofs_t          latched_reg, latched_next;
    phase_t        phase_reg, phase_next;
    ofs_t          phase_offset_reg [4];

    // memories
    audio_t        sample_store_mem [STORE_DEPTH];
    tval_t         tbl_mem [TBL_DEPTH];
    tval_t         tq_reg;
    audio_t        store_q_reg;

    // pipeline
    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    tap_kind_t     s1_kind_reg;
    ofs_t          s1_knob_reg;
    logic [AW-1:0] s1_wp_reg, s2_wp_reg;
    logic          s1_full_reg, s2_full_reg;
    logic          s1_wr_reg, s2_wr_reg;
    logic [AW-1:0] s1_waddr_reg, s2_waddr_reg;
    audio_t        s1_sample_reg, s2_sample_reg, s3_sample_reg;
    logic [AW-1:0] s2_d_reg;
    logic          s3_fwd_reg, s3_zero_reg;

    logic          s1_free, s2_free, s3_free;
    logic          tick, tbl_wr, do_write, emit, wrap;
    tap_kind_t     kind;
    sel_t          tsel;
    ofs_t          rv;
    logic [KW-1:0] tix, tidx_k;
    logic          rd_tbl;
    tval_t         delay1;
    logic [AW-1:0] d1;
    logic [AW:0]   diff2;
    logic [AW-1:0] idx2;
    logic          entry_ok2, fwd2;

    assign s3_free  = !s3_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;

    assign tick   = in_valid && s1_free && (action == ACTION_TICK);
    assign tbl_wr = in_valid && s1_free && (action == ACTION_TABLE)
                    && (32'(table_index) < KNOB_STEPS)
                    && (table_select inside {SEL_A, SEL_B, SEL_C});
    assign tidx_k = KW'(table_index);

    always_comb
    begin
        do_write   = 1'b0;
        emit       = 1'b0;
        kind       = KIND_A;
        tsel       = SEL_A;
        phase_next = phase_reg;
        if (tick)
        begin
            unique case (mode)
                MODE_A:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        do_write   = 1'b1;
                        emit       = 1'b1;
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        phase_next = 2'd0;
                    end
                end
                MODE_B:
                begin
                    kind = KIND_B;
                    tsel = SEL_B;
                    if (phase_reg == 2'd0)
                    begin
                        do_write   = 1'b1;
                        emit       = 1'b1;
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
                MODE_DIRECT:
                begin
                    kind     = KIND_DIRECT;
                    do_write = 1'b1;
                    emit     = 1'b1;
                end
                MODE_MULTI:
                begin
                    kind       = KIND_C;
                    tsel       = SEL_C;
                    do_write   = (phase_reg == 2'd0);
                    emit       = 1'b1;
                    phase_next = phase_reg + 2'd1;
                end
                default: ;
            endcase
        end

        wrap = do_write && (wp_reg == AW'(STORE_DEPTH - 1));
        if (!do_write)
            wp_next = wp_reg;
        else if (wrap)
            wp_next = '0;
        else
            wp_next = wp_reg + 1'b1;
        latched_next = wrap ? delay_knob[KNOB_W-1:KNOB_W-OFS_W] : latched_reg;
        full_next    = full_reg || wrap;

        // mode 3 index wraps at 10 bits before the table reduction
        rv     = (kind == KIND_C) ? latched_next + phase_offset_reg[phase_reg] : latched_next;
        tix    = knob_mod(rv);
        rd_tbl = emit && (kind != KIND_DIRECT);
    end

    // delay tables: an entry write and a tap read never share an edge
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
            tbl_mem[{table_select, tidx_k}] <= table_value;
        if (rd_tbl)
            tq_reg <= tbl_mem[{tsel, tix}];
    end

    // stage 1: pick delay and reduce it modulo the store depth
    always_comb
    begin
        case (s1_kind_reg)
            KIND_DIRECT: delay1 = TVAL_W'(s1_knob_reg);
            default:     delay1 = tq_reg;
        endcase
        d1 = depth_mod(delay1);
    end

    // stage 2: read address behind the position after the write
    always_comb
    begin
        if (s2_wp_reg >= s2_d_reg)
            diff2 = {1'b0, s2_wp_reg} - {1'b0, s2_d_reg};
        else
            diff2 = {1'b0, s2_wp_reg} + (AW+1)'(STORE_DEPTH) - {1'b0, s2_d_reg};
        idx2      = diff2[AW-1:0];
        entry_ok2 = s2_full_reg || (idx2 < s2_wp_reg);
        fwd2      = s2_wr_reg && (idx2 == s2_waddr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            if (s2_wr_reg)
                sample_store_mem[s2_waddr_reg] <= s2_sample_reg;
            store_q_reg <= sample_store_mem[idx2];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            latched_reg  <= '0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                phase_offset_reg[i] <= '0;
        end
        else
        begin
            wp_reg      <= wp_next;
            full_reg    <= full_next;
            latched_reg <= latched_next;
            phase_reg   <= phase_next;
            if (s1_free)
                s1_valid_reg <= emit;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (cfg_we)
                phase_offset_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_free && emit)
        begin
            s1_kind_reg   <= kind;
            s1_knob_reg   <= latched_next;
            s1_wp_reg     <= wp_next;
            s1_full_reg   <= full_next;
            s1_wr_reg     <= do_write;
            s1_waddr_reg  <= wp_reg;
            s1_sample_reg <= audio_in;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_d_reg      <= d1;
            s2_wp_reg     <= s1_wp_reg;
            s2_full_reg   <= s1_full_reg;
            s2_wr_reg     <= s1_wr_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_sample_reg <= s1_sample_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_fwd_reg    <= fwd2;
            s3_zero_reg   <= !entry_ok2;
            s3_sample_reg <= s2_sample_reg;
        end
    end

    assign out_valid = s3_valid_reg;

    always_comb
    begin
        if (s3_fwd_reg)
            delayed_sample = s3_sample_reg;
        else if (s3_zero_reg)
            delayed_sample = '0;
        else
            delayed_sample = store_q_reg;
    end

endmodule

`default_nettype wire

@@ hdl/madl_checker.sv @@
`default_nettype none

module madl_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              in_valid,
    input wire              in_stall,
    input wire              action,
    input wire              out_valid,
    input wire              out_stall,
    input madl_pkg::audio_t delayed_sample
);
    import madl_pkg::*;

    // input backs up only when the whole pipeline sits behind a blocked result
    a_stall_needs_blocked_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output is not blocked");

    // a fresh result comes from an accepted tick carried through the pipeline registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && (action == ACTION_TICK), 3))
        else $error("result without a matching tick");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(delayed_sample))
        else $error("stalled output item changed");

endmodule

bind multimode_audio_delay_line_unit madl_checker u_madl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .delayed_sample (delayed_sample)
);

`default_nettype wire
